>>> hdl/srs_pkg.sv
// Shared types, codes and field widths of the selective-repeat sender.
`timescale 1ns / 1ps

package srs_pkg;

    localparam int OPCODE_W  = 2;
    localparam int SEQ_FLD_W = 3;
    localparam int PAY_FLD_W = 32;
    localparam int STATUS_W  = 3;

    localparam int DEF_WINDOW       = 4;
    localparam int DEF_SEQ_SPACE    = 8;
    localparam int DEF_PAYLOAD_BITS = 32;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SEND    = 2'd0,
        OP_ACK     = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_REFUSED = 3'd0,
        ST_SENT    = 3'd1,
        ST_ACK_OK  = 3'd2,
        ST_ACK_IGN = 3'd3,
        ST_RETX    = 3'd4
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic slide_step;
        logic load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ack_slides;
        logic slide_more;
        logic out_free;
    } t_stat;

endpackage

>>> hdl/srs_if.sv
// Request and result channel interfaces of the selective-repeat sender.
`timescale 1ns / 1ps

interface srs_in_if;
    import srs_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OPCODE_W-1:0]  opcode;
    logic [PAY_FLD_W-1:0] payload_word;
    logic [SEQ_FLD_W-1:0] ack_seq;
    logic                 ack_checksum_ok;
    logic [SEQ_FLD_W-1:0] timeout_seq;

    modport source (output valid, opcode, payload_word, ack_seq, ack_checksum_ok,
                    timeout_seq, input ready);
    modport sink (input valid, opcode, payload_word, ack_seq, ack_checksum_ok,
                  timeout_seq, output ready);
endinterface

interface srs_out_if;
    import srs_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic                 tx_valid;
    logic [SEQ_FLD_W-1:0] tx_seq;
    logic [PAY_FLD_W-1:0] tx_payload;
    logic [SEQ_FLD_W-1:0] timer_seq;
    logic                 timer_restart;
    logic                 timer_stop;
    logic                 window_full;
    logic [SEQ_FLD_W-1:0] window_base;
    logic [SEQ_FLD_W-1:0] next_seq;

    modport source (output valid, status, tx_valid, tx_seq, tx_payload, timer_seq,
                    timer_restart, timer_stop, window_full, window_base, next_seq,
                    input ready);
    modport sink (input valid, status, tx_valid, tx_seq, tx_payload, timer_seq,
                  timer_restart, timer_stop, window_full, window_base, next_seq,
                  output ready);
endinterface

>>> hdl/srs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module srs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/srs_ctrl.sv
// Controller state machine of the selective-repeat sender.
`timescale 1ns / 1ps

module srs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    srs_in_if.sink         i_in,
    input  srs_pkg::t_stat i_stat,
    output srs_pkg::t_cmd  o_cmd
);
    import srs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_SLIDE = 4'b0100,
        S_LOAD  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        i_in.ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                // An unused opcode is taken and dropped without a result.
                if (i_in.valid && i_in.opcode != OP_NONE) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = i_stat.ack_slides ? S_SLIDE : S_LOAD;
            end
            S_SLIDE: begin
                if (i_stat.slide_more) begin
                    o_cmd.slide_step = 1'b1;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hdl/srs_dp.sv
// Datapath of the selective-repeat sender: window state, acked marks,
// packet store and result register.
`timescale 1ns / 1ps

module srs_dp #(
    parameter int WINDOW       = srs_pkg::DEF_WINDOW,
    parameter int SEQ_SPACE    = srs_pkg::DEF_SEQ_SPACE,
    parameter int PAYLOAD_BITS = srs_pkg::DEF_PAYLOAD_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    srs_in_if.sink         i_in,
    srs_out_if.source      o_out,
    input  srs_pkg::t_cmd  i_cmd,
    output srs_pkg::t_stat o_stat
);
    import srs_pkg::*;

    localparam int SEQ_W   = $clog2(SEQ_SPACE);
    localparam int EFF_WIN = (WINDOW < SEQ_SPACE) ? WINDOW : SEQ_SPACE - 1;
    localparam int STORE_W = (PAYLOAD_BITS < PAY_FLD_W) ? PAYLOAD_BITS : PAY_FLD_W;

    function automatic logic [SEQ_W-1:0] f_inc(input logic [SEQ_W-1:0] a_seq);
        return (a_seq == SEQ_W'(SEQ_SPACE - 1)) ? '0 : a_seq + 1'b1;
    endfunction

    function automatic logic [SEQ_W-1:0] f_dist(input logic [SEQ_W-1:0] a_from,
                                                input logic [SEQ_W-1:0] a_to);
        logic [SEQ_W:0] d;
        d = {1'b0, a_to} - {1'b0, a_from};
        if (d[SEQ_W]) begin
            d = d + (SEQ_W+1)'(SEQ_SPACE);
        end
        return d[SEQ_W-1:0];
    endfunction

    // Window state and acked marks.
    logic [SEQ_W-1:0]     r_base, n_base;
    logic [SEQ_W-1:0]     r_next, n_next;
    logic [SEQ_SPACE-1:0] r_mark, n_mark;

    // Captured item.
    t_op                  r_op;
    logic [STORE_W-1:0]   r_payload;
    logic [SEQ_W-1:0]     r_seq;
    logic                 r_ack_good;

    // Result fields worked out during execution.
    t_status              r_status, n_status;
    logic                 r_txv, n_txv;
    logic [SEQ_W-1:0]     r_txs, n_txs;
    logic [SEQ_W-1:0]     r_tms, n_tms;
    logic                 r_tmr, n_tmr;
    logic                 r_tmst, n_tmst;

    // Output register.
    logic                 r_out_valid, n_out_valid;
    t_status              r_o_status;
    logic                 r_o_txv;
    logic [SEQ_W-1:0]     r_o_txs;
    logic [STORE_W-1:0]   r_o_payload;
    logic [SEQ_W-1:0]     r_o_tms;
    logic                 r_o_tmr;
    logic                 r_o_tmst;
    logic                 r_o_full;
    logic [SEQ_W-1:0]     r_o_base;
    logic [SEQ_W-1:0]     r_o_next;

    logic                 full;
    logic                 ack_ok;
    logic [SEQ_W-1:0]     timeout_mod;
    logic                 ack_in_range;
    logic                 ram_we;
    logic                 ram_re;
    logic [STORE_W-1:0]   ram_rdata;

    assign full = f_dist(r_base, r_next) >= SEQ_W'(EFF_WIN);
    assign ack_ok = (r_base != r_next) && r_ack_good
                    && (f_dist(r_base, r_seq) < SEQ_W'(EFF_WIN));
    assign ack_in_range = 32'(i_in.ack_seq) < SEQ_SPACE;

    // Timeout number reduced modulo the sequence space by repeated subtraction.
    always_comb begin
        logic [SEQ_FLD_W+1:0] v;
        v = (SEQ_FLD_W+2)'(i_in.timeout_seq);
        for (int k = 0; k < 7; k++) begin
            if (v >= (SEQ_FLD_W+2)'(SEQ_SPACE)) begin
                v = v - (SEQ_FLD_W+2)'(SEQ_SPACE);
            end
        end
        timeout_mod = SEQ_W'(v);
    end

    assign o_stat.ack_slides = i_cmd.exec && r_op == OP_ACK && ack_ok && r_seq == r_base;
    assign o_stat.slide_more = (r_base != r_next) && r_mark[r_base];
    assign o_stat.out_free   = !r_out_valid || o_out.ready;

    assign ram_we = i_cmd.exec && r_op == OP_SEND && !full;
    assign ram_re = i_cmd.exec && r_op == OP_TIMEOUT;

    srs_ram #(
        .WIDTH (STORE_W),
        .DEPTH (SEQ_SPACE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_next),
        .i_wdata (r_payload),
        .i_re    (ram_re),
        .i_raddr (r_seq),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_base      = r_base;
        n_next      = r_next;
        n_mark      = r_mark;
        n_status    = r_status;
        n_txv       = r_txv;
        n_txs       = r_txs;
        n_tms       = r_tms;
        n_tmr       = r_tmr;
        n_tmst      = r_tmst;
        n_out_valid = r_out_valid;

        if (i_cmd.exec) begin
            n_txv  = 1'b0;
            n_txs  = '0;
            n_tms  = '0;
            n_tmr  = 1'b0;
            n_tmst = 1'b0;
            unique case (r_op)
                OP_SEND: begin
                    if (full) begin
                        n_status = ST_REFUSED;
                    end else begin
                        n_mark[r_next] = 1'b0;
                        n_next   = f_inc(r_next);
                        n_status = ST_SENT;
                        n_txv    = 1'b1;
                        n_txs    = r_next;
                        n_tms    = r_next;
                        n_tmr    = 1'b1;
                    end
                end
                OP_ACK: begin
                    if (ack_ok) begin
                        n_mark[r_seq] = 1'b1;
                        n_status = ST_ACK_OK;
                        n_tms    = r_seq;
                        n_tmst   = 1'b1;
                    end else begin
                        n_status = ST_ACK_IGN;
                    end
                end
                OP_TIMEOUT: begin
                    n_status = ST_RETX;
                    n_txv    = 1'b1;
                    n_txs    = r_seq;
                    n_tms    = r_seq;
                    n_tmr    = 1'b1;
                end
                default: begin
                    n_status = ST_ACK_IGN;
                end
            endcase
        end

        if (i_cmd.slide_step) begin
            n_base = f_inc(r_base);
        end

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_next      <= '0;
            r_mark      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_base      <= n_base;
            r_next      <= n_next;
            r_mark      <= n_mark;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_txv    <= n_txv;
        r_txs    <= n_txs;
        r_tms    <= n_tms;
        r_tmr    <= n_tmr;
        r_tmst   <= n_tmst;
        if (i_cmd.capture) begin
            r_op       <= t_op'(i_in.opcode);
            r_payload  <= i_in.payload_word[STORE_W-1:0];
            r_seq      <= (i_in.opcode == OP_ACK) ? SEQ_W'(i_in.ack_seq) : timeout_mod;
            r_ack_good <= i_in.ack_checksum_ok && ack_in_range;
        end
        if (i_cmd.load) begin
            r_o_status <= r_status;
            r_o_txv    <= r_txv;
            r_o_txs    <= r_txs;
            r_o_tms    <= r_tms;
            r_o_tmr    <= r_tmr;
            r_o_tmst   <= r_tmst;
            r_o_full   <= full;
            r_o_base   <= r_base;
            r_o_next   <= r_next;
            if (!r_txv) begin
                r_o_payload <= '0;
            end else if (r_op == OP_TIMEOUT) begin
                r_o_payload <= ram_rdata;
            end else begin
                r_o_payload <= r_payload;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_o_status;
    assign o_out.tx_valid      = r_o_txv;
    assign o_out.tx_seq        = SEQ_FLD_W'(r_o_txs);
    assign o_out.tx_payload    = PAY_FLD_W'(r_o_payload);
    assign o_out.timer_seq     = SEQ_FLD_W'(r_o_tms);
    assign o_out.timer_restart = r_o_tmr;
    assign o_out.timer_stop    = r_o_tmst;
    assign o_out.window_full   = r_o_full;
    assign o_out.window_base   = SEQ_FLD_W'(r_o_base);
    assign o_out.next_seq      = SEQ_FLD_W'(r_o_next);

endmodule

>>> hdl/selective_repeat_sender_unit.sv
// Top level of the selective-repeat ARQ sender.
//
//   port    dir   handshake     beat contents
//   i_in    in    valid/ready   opcode, payload_word, ack_seq, ack_checksum_ok, timeout_seq
//   o_out   out   valid/ready   status, tx and timer commands, window_full/base, next_seq
//
// After its beat is accepted an item passes through S_EXEC and then S_LOAD, which loads the
// result into o_out, and the next beat is taken back in S_IDLE. An ack of the base also passes
// through S_SLIDE, which slides the window base over acked entries (up to the window size).
// One item is in work at a time; a new beat is taken while a result waits in o_out.
// Reset is synchronous: base, next number and acked marks clear; the packet store
// is not cleared. A stalled o_out holds the controller before it loads the result.
`timescale 1ns / 1ps

module selective_repeat_sender_unit #(
    parameter int WINDOW       = srs_pkg::DEF_WINDOW,
    parameter int SEQ_SPACE    = srs_pkg::DEF_SEQ_SPACE,
    parameter int PAYLOAD_BITS = srs_pkg::DEF_PAYLOAD_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    srs_in_if.sink    i_in,
    srs_out_if.source o_out
);
    import srs_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    srs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    srs_dp #(
        .WINDOW       (WINDOW),
        .SEQ_SPACE    (SEQ_SPACE),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.capture, cmd.exec, cmd.slide_step, cmd.load}))
        else $error("controller issued more than one command");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> stat.out_free)
        else $error("result loaded over an untaken beat");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.opcode != OP_NONE) |=> cmd.exec)
        else $error("accepted beat not executed in the next cycle");

    a_slide_needed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.slide_step |-> stat.slide_more)
        else $error("base slid over an entry that is not acked");

    a_sent_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_SENT) |->
        (o_out.tx_valid && o_out.timer_restart && o_out.tx_seq == o_out.timer_seq))
        else $error("sent result without matching transmit and timer command");

endmodule
